// ----- sv/jfp_pkg.sv -----
// ----------------------------------------------------------------------------
// jfp_pkg
// Shared types and constants for the joystick frame parser.
// ----------------------------------------------------------------------------
package jfp_pkg;

  localparam int ByteW  = 8;
  localparam int WordW  = 16;
  localparam int SpeedW = 11;
  localparam int CountW = 4;
  localparam int WordCnt = 3;

  localparam logic [ByteW-1:0]  HdrA = 8'hAA;
  localparam logic [ByteW-1:0]  HdrB = 8'h55;

  localparam logic [CountW-1:0] CntFirst = 4'd1;
  localparam logic [CountW-1:0] DataPos  = 4'd2;
  localparam logic [CountW-1:0] CheckPos = 4'd8;
  localparam logic [CountW-1:0] CntZero  = 4'd0;

  localparam int AdcMid    = 2048;
  localparam int DeadBand  = 100;
  localparam int FullSpeed = 1000;
  localparam int Span      = AdcMid - DeadBand;

  localparam int AdcW = 12;
  localparam int OffW = AdcW + 1;
  localparam int MagW = 11;

  // q = floor(m * FullSpeed / Span) == (m * MapMul) >> MapShift for m <= Span
  localparam int MapShift = 24;
  localparam longint MapNum = longint'(FullSpeed) <<< MapShift;
  localparam longint MapMulL = (MapNum + longint'(Span) - 1) / longint'(Span);
  localparam int MapMulW = 24;
  localparam logic [MapMulW-1:0] MapMul = MapMulW'(MapMulL);
  localparam int ProdW = MagW + MapMulW;

  typedef enum logic [1:0] {
    PS_HUNT = 2'd0,
    PS_HDR2 = 2'd1,
    PS_DATA = 2'd2
  } parse_state_t;

  typedef logic [WordCnt-1:0][WordW-1:0] word_arr_t;

  typedef struct packed {
    logic      chk_ok;
    word_arr_t words;
  } frame_t;

endpackage

// ----- sv/jfp_frame_fsm.sv -----
// ----------------------------------------------------------------------------
// jfp_frame_fsm
// Header hunt, running checksum and ADC word assembly, one byte per step.
// ----------------------------------------------------------------------------
module jfp_frame_fsm import jfp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [ByteW-1:0] rx_byte,
  output frame_t           frame
);

  parse_state_t      state_r, state_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [ByteW-1:0]  sum_r, sum_nxt;
  word_arr_t         words_r;
  logic              wr_en;
  logic [1:0]        wr_idx;
  logic              wr_hi;
  logic [CountW-1:0] cnt_off;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PS_HUNT;
      count_r <= CntZero;
      sum_r   <= '0;
    end else if (step) begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WordCnt; i++) begin
      if (step && wr_en && (wr_idx == 2'(i))) begin
        words_r[i] <= wr_hi ? {rx_byte, words_r[i][ByteW-1:0]} : {{ByteW{1'b0}}, rx_byte};
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    unique case (state_r)
      PS_HUNT: begin
        if (rx_byte == HdrA) begin
          sum_nxt   = rx_byte;
          count_nxt = CntFirst;
          state_nxt = PS_HDR2;
        end
      end
      PS_HDR2: begin
        if (rx_byte == HdrB) begin
          sum_nxt   = sum_r + rx_byte;
          count_nxt = DataPos;
          state_nxt = PS_DATA;
        end else if (rx_byte == HdrA) begin
          sum_nxt   = rx_byte;
          count_nxt = CntFirst;
        end else begin
          state_nxt = PS_HUNT;
        end
      end
      PS_DATA: begin
        if (count_r >= DataPos && count_r < CheckPos) begin
          sum_nxt   = sum_r + rx_byte;
          count_nxt = count_r + CntFirst;
        end else if (count_r < DataPos) begin
          count_nxt = DataPos;
          state_nxt = PS_HUNT;
        end else begin
          count_nxt = CntZero;
          state_nxt = PS_HUNT;
        end
      end
      default: state_nxt = PS_HUNT;
    endcase
  end

  // outputs
  always_comb begin
    cnt_off      = count_r - DataPos;
    wr_idx       = cnt_off[2:1];
    wr_hi        = count_r[0];
    wr_en        = 1'b0;
    frame.chk_ok = 1'b0;
    unique case (state_r)
      PS_DATA: begin
        wr_en        = (count_r >= DataPos) && (count_r < CheckPos);
        frame.chk_ok = (count_r >= CheckPos) && (sum_r == rx_byte);
      end
      default: ;
    endcase
    frame.words = words_r;
  end

endmodule

// ----- sv/jfp_speed_map.sv -----
// ----------------------------------------------------------------------------
// jfp_speed_map
// Clamps one ADC word, applies the deadzone and scales it to a signed speed.
// ----------------------------------------------------------------------------
module jfp_speed_map import jfp_pkg::*; (
  input  logic [WordW-1:0]         word,
  output logic signed [SpeedW-1:0] speed
);

  logic [AdcW-1:0]        adc;
  logic signed [OffW-1:0] off;
  logic                   pos, neg;
  logic [OffW-1:0]        mag_full;
  logic [MagW-1:0]        mag;
  logic [ProdW-1:0]       prod;
  logic [SpeedW-1:0]      q;

  always_comb begin
    adc = (word > WordW'((1 << AdcW) - 1)) ? {AdcW{1'b1}} : word[AdcW-1:0];
    off = signed'({1'b0, adc}) - OffW'(AdcMid);
    pos = off > OffW'(DeadBand);
    neg = off < -OffW'(DeadBand);
    if (pos) begin
      mag_full = off - OffW'(DeadBand);
    end else if (neg) begin
      mag_full = -(off + OffW'(DeadBand));
    end else begin
      mag_full = '0;
    end
    mag  = mag_full[MagW-1:0];
    prod = ProdW'(mag) * ProdW'(MapMul);
    q    = prod[MapShift +: SpeedW];
    speed = neg ? -signed'(q) : signed'(q);
  end

endmodule

// ----- sv/joystick_frame_parser_unit.sv -----
// ----------------------------------------------------------------------------
// joystick_frame_parser_unit
// Byte-stream frame parser producing three joystick speeds per good frame.
// ----------------------------------------------------------------------------
// Result path: byte stage register, then output register with the speeds.
// Throughput: one byte per cycle; the byte stage stalls only while a finished
//   result waits in the output register and the next byte completes a good
//   frame.
// Reset clears the parse state, byte count, running sum and both valid flags;
//   the assembled ADC words hold their value until overwritten.
// ----------------------------------------------------------------------------
module joystick_frame_parser_unit import jfp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [ByteW-1:0]         in_rx_byte,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [SpeedW-1:0] out_speed_x,
  output logic signed [SpeedW-1:0] out_speed_y,
  output logic signed [SpeedW-1:0] out_turn_rate
);

  logic                     s1_v_r, s1_v_nxt;
  logic [ByteW-1:0]         s1_byte_r;
  logic                     s1_go;
  logic                     emit;
  frame_t                   frame;
  logic signed [SpeedW-1:0] spd_x, spd_y, spd_t;
  logic                     out_v_r, out_v_nxt;
  logic signed [SpeedW-1:0] sx_r, sy_r, st_r;

  jfp_frame_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_go),
    .rx_byte (s1_byte_r),
    .frame   (frame)
  );

  jfp_speed_map u_map_x (.word(frame.words[0]), .speed(spd_x));
  jfp_speed_map u_map_y (.word(frame.words[1]), .speed(spd_y));
  jfp_speed_map u_map_t (.word(frame.words[2]), .speed(spd_t));

  always_comb begin
    emit     = s1_v_r && frame.chk_ok;
    s1_go    = s1_v_r && (!frame.chk_ok || !out_v_r || out_ready);
    in_ready = !s1_v_r || s1_go;
    if (in_valid && in_ready) begin
      s1_v_nxt = 1'b1;
    end else if (s1_go) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
    if (s1_go && emit) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
    end
    if (s1_go && emit) begin
      sx_r <= spd_x;
      sy_r <= spd_y;
      st_r <= spd_t;
    end
  end

  assign out_valid     = out_v_r;
  assign out_speed_x   = sx_r;
  assign out_speed_y   = sy_r;
  assign out_turn_rate = st_r;

endmodule

// ----- sv/jfp_checker.sv -----
// ----------------------------------------------------------------------------
// jfp_checker
// Port-level checks for the joystick frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module jfp_checker import jfp_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic [ByteW-1:0]         in_rx_byte,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [SpeedW-1:0] out_speed_x,
  input logic signed [SpeedW-1:0] out_speed_y,
  input logic signed [SpeedW-1:0] out_turn_rate
);

  localparam logic signed [SpeedW-1:0] SpdMax = SpeedW'(FullSpeed);
  localparam logic signed [SpeedW-1:0] SpdMin = -SpeedW'(FullSpeed);

  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_rx_byte))
    else $error("stalled input transfer changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_speed_x)
      && $stable(out_speed_y) && $stable(out_turn_rate))
    else $error("stalled result changed");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_speed_x <= SpdMax && out_speed_x >= SpdMin
      && out_speed_y <= SpdMax && out_speed_y >= SpdMin
      && out_turn_rate <= SpdMax && out_turn_rate >= SpdMin)
    else $error("speed out of range");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

endmodule

bind joystick_frame_parser_unit jfp_checker u_jfp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_rx_byte    (in_rx_byte),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_speed_x   (out_speed_x),
  .out_speed_y   (out_speed_y),
  .out_turn_rate (out_turn_rate)
);

// ----- verif/jfp_frame_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jfp_frame_checker
// Follows every byte transfer into the parser and keeps its own header hunt,
// running sum and word assembly. On a good checksum it queues the three
// expected speeds. Each result transfer is compared field by field with the
// oldest queued set. Unexpected results and mismatches are counted.
// ----------------------------------------------------------------------------
module jfp_frame_checker import jfp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [ByteW-1:0]         in_rx_byte,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [SpeedW-1:0] out_speed_x,
  input  logic signed [SpeedW-1:0] out_speed_y,
  input  logic signed [SpeedW-1:0] out_turn_rate,
  output int                       fail_count,
  output int                       speeds_due_count
);

  localparam int AdcMax = (1 << AdcW) - 1;

  typedef struct packed {
    logic signed [SpeedW-1:0] x;
    logic signed [SpeedW-1:0] y;
    logic signed [SpeedW-1:0] turn;
  } speed_set_t;

  speed_set_t       speeds_due [$];
  parse_state_t     hunt_state;
  logic [CountW-1:0] frame_pos;
  logic [ByteW-1:0] frame_sum;
  logic [WordW-1:0] adc_words [WordCnt];
  int               mismatches = 0;

  function automatic logic signed [SpeedW-1:0] speed_of(logic [WordW-1:0] w);
    int v;
    int off;
    int r;
    v = (int'(w) > AdcMax) ? AdcMax : int'(w);
    off = v - AdcMid;
    r = 0;
    if (off > DeadBand) r = (off - DeadBand) * FullSpeed / Span;
    else if (off < -DeadBand) r = (off + DeadBand) * FullSpeed / Span;
    return SpeedW'(r);
  endfunction

  function automatic void check_speed(string field, logic signed [SpeedW-1:0] want,
                                      logic signed [SpeedW-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  task automatic parse_byte(input logic [ByteW-1:0] b);
    int k;
    case (hunt_state)
      PS_HUNT: begin
        if (b == HdrA) begin
          frame_sum = b;
          frame_pos = CntFirst;
          hunt_state = PS_HDR2;
        end
      end
      PS_HDR2: begin
        if (b == HdrB) begin
          frame_sum = frame_sum + b;
          frame_pos = DataPos;
          hunt_state = PS_DATA;
        end else if (b == HdrA) begin
          frame_sum = b;
          frame_pos = CntFirst;
        end else begin
          hunt_state = PS_HUNT;
        end
      end
      PS_DATA: begin
        if (frame_pos >= DataPos && frame_pos < CheckPos) begin
          k = int'((frame_pos - DataPos) >> 1);
          if (!frame_pos[0]) adc_words[k] = {{(WordW-ByteW){1'b0}}, b};
          else adc_words[k][WordW-1:ByteW] = b;
          frame_sum = frame_sum + b;
          frame_pos = frame_pos + 1'b1;
        end else if (frame_pos < DataPos) begin
          frame_pos = DataPos;
          hunt_state = PS_HUNT;
        end else begin
          hunt_state = PS_HUNT;
          frame_pos = CntZero;
          if (frame_sum == b)
            speeds_due.push_back('{x: speed_of(adc_words[0]), y: speed_of(adc_words[1]),
                                   turn: speed_of(adc_words[2])});
        end
      end
      default: hunt_state = PS_HUNT;
    endcase
  endtask

  always @(posedge clk) begin
    speed_set_t want;
    if (!rst_n) begin
      hunt_state = PS_HUNT;
      frame_pos = CntZero;
      frame_sum = '0;
      foreach (adc_words[i]) adc_words[i] = '0;
      speeds_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (speeds_due.size() == 0) begin
          $error("result transfer with no good frame pending: x=%0d y=%0d turn=%0d",
                 out_speed_x, out_speed_y, out_turn_rate);
          mismatches++;
        end else begin
          want = speeds_due.pop_front();
          check_speed("speed_x", want.x, out_speed_x);
          check_speed("speed_y", want.y, out_speed_y);
          check_speed("turn_rate", want.turn, out_turn_rate);
        end
      end
      if (in_valid && in_ready) parse_byte(in_rx_byte);
    end
    fail_count <= mismatches;
    speeds_due_count <= speeds_due.size();
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Byte stream stimulus for the joystick frame parser: a few directed frames
// and header cases, then mostly well-formed frames with random ADC words,
// mixed with bad checksums, header restarts, cut-off frames and noise.
// Both channels idle at random; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import jfp_pkg::*;

  localparam int ByteBudget = 1075;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [ByteW-1:0]         in_rx_byte = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [SpeedW-1:0] out_speed_x;
  logic signed [SpeedW-1:0] out_speed_y;
  logic signed [SpeedW-1:0] out_turn_rate;
  int                       fail_count;
  int                       speeds_due_count;
  int                       bytes_sent = 0;
  int                       burst_left = 0;
  int                       ready_hold = 0;

  always #6 clk = ~clk;

  joystick_frame_parser_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_speed_x  (out_speed_x),
    .out_speed_y  (out_speed_y),
    .out_turn_rate(out_turn_rate)
  );

  jfp_frame_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_speed_x     (out_speed_x),
    .out_speed_y     (out_speed_y),
    .out_turn_rate   (out_turn_rate),
    .fail_count      (fail_count),
    .speeds_due_count(speeds_due_count)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side: holds ready or stall for a random stretch
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready <= ($urandom_range(0, 9) < 7);
      ready_hold <= pick_gap();
    end
  end

  function automatic logic [WordW-1:0] pick_word();
    case ($urandom_range(0, 5))
      0: return WordW'($urandom);
      1: return WordW'($urandom_range(AdcMid - 140, AdcMid + 140));
      2: return WordW'($urandom_range(4000, 4200));
      3: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          2: return WordW'(12'hFFF);
          default: return WordW'(AdcMid);
        endcase
      end
      default: return WordW'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(30, 120);
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [WordW-1:0] w0, w1, w2,
                            input logic [ByteW-1:0] chk_flip);
    logic [ByteW-1:0] frame_bytes [9];
    logic [ByteW-1:0] sum;
    frame_bytes[0] = HdrA;
    frame_bytes[1] = HdrB;
    {frame_bytes[3], frame_bytes[2]} = w0;
    {frame_bytes[5], frame_bytes[4]} = w1;
    {frame_bytes[7], frame_bytes[6]} = w2;
    sum = '0;
    for (int i = 0; i < 8; i++) sum = sum + frame_bytes[i];
    frame_bytes[8] = sum ^ chk_flip;
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
  endtask

  initial begin
    int r;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_byte(8'h00);
    send_byte(HdrA);
    send_byte(8'h12);
    send_byte(HdrA);
    send_frame(16'h0000, 16'hFFFF, 16'h0FFF, 8'h00);
    send_frame(16'h0800, 16'h07FF, 16'h0801, 8'h01);

    while (bytes_sent < ByteBudget) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        send_frame(pick_word(), pick_word(), pick_word(), 8'h00);
      end else if (r < 70) begin
        send_frame(pick_word(), pick_word(), pick_word(), ByteW'($urandom_range(1, 255)));
      end else if (r < 78) begin
        repeat ($urandom_range(1, 3)) send_byte(HdrA);
        send_frame(pick_word(), pick_word(), pick_word(), 8'h00);
      end else if (r < 86) begin
        send_byte(HdrA);
        send_byte(HdrB);
        repeat ($urandom_range(0, 6)) send_byte(ByteW'($urandom));
      end else if (r < 92) begin
        send_byte(HdrA);
        send_byte(ByteW'($urandom));
      end else begin
        repeat ($urandom_range(1, 5)) send_byte(ByteW'($urandom));
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (speeds_due_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("joystick_frame_parser_unit verification clean");
    end else begin
      $display("joystick_frame_parser_unit verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("joystick_frame_parser_unit verification failed");
    $finish;
  end

endmodule
